@@ hw/rtl/utf8nf_pkg.sv @@
// ----------------------------------------------------------------------------
// utf8nf_pkg
// Shared types and byte-class constants for the UTF-8 name flag detector.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8nf_pkg;

  // Byte classes and framing masks
  localparam logic [7:0] CtrlLimit   = 8'h20;  // below this: control byte
  localparam logic [7:0] PrintMax    = 8'h7d;  // above this: needs flag, or is a lead or invalid byte
  localparam logic [7:0] Backslash   = 8'h5c;
  localparam logic [7:0] AsciiLimit  = 8'h80;
  localparam logic [1:0] ContTag     = 2'b10;     // 10xxxxxx
  localparam logic [2:0] Lead2Tag    = 3'b110;    // 110xxxxx
  localparam logic [3:0] Lead3Tag    = 4'b1110;   // 1110xxxx
  localparam logic [4:0] Lead4Tag    = 5'b11110;  // 11110xxx

  // Per-name tracking state
  typedef struct packed {
    logic [1:0] cont_left;
    logic       valid_so_far;
    logic       require_so_far;
    logic       stopped;
  } utf8nf_state_t;

  localparam utf8nf_state_t StateReset = '{
    cont_left:      2'd0,
    valid_so_far:   1'b1,
    require_so_far: 1'b0,
    stopped:        1'b0
  };

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last_byte;
  } utf8nf_item_t;

  // One result item
  typedef struct packed {
    logic utf8_valid;
    logic needs_utf8_flag;
  } utf8nf_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/utf8nf_if.sv @@
// ----------------------------------------------------------------------------
// utf8nf_in_if / utf8nf_out_if
// Valid/ready channels for name bytes and for per-name results.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8nf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       last_byte;

  modport source (output valid, output data_byte, output byte_present,
                  output last_byte, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input last_byte, output ready);
endinterface

interface utf8nf_out_if;
  logic valid;
  logic ready;
  logic utf8_valid;
  logic needs_utf8_flag;

  modport source (output valid, output utf8_valid, output needs_utf8_flag,
                  input ready);
  modport sink   (input valid, input utf8_valid, input needs_utf8_flag,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/utf8nf_byte_step.sv @@
// ----------------------------------------------------------------------------
// utf8nf_byte_step
// Combinational update of the per-name state for one item, plus the result
// that a last-marked item reports.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8nf_byte_step (
  input  utf8nf_pkg::utf8nf_state_t  state_i,
  input  utf8nf_pkg::utf8nf_item_t   item_i,
  output utf8nf_pkg::utf8nf_state_t  state_o,
  output utf8nf_pkg::utf8nf_result_t result_o
);
  import utf8nf_pkg::*;

  utf8nf_state_t after_byte;
  utf8nf_state_t at_end;
  logic [7:0]    b;
  logic          special;

  assign b       = item_i.data_byte;
  // Bytes outside the plain printable range, and the backslash, need a closer look
  assign special = (b < CtrlLimit) || (b > PrintMax) || (b == Backslash);

  // Framing and flag update for a present byte
  always_comb begin
    after_byte = state_i;
    if (item_i.byte_present && !state_i.stopped) begin
      if (state_i.cont_left != 2'd0) begin
        if (b[7:6] != ContTag) begin
          after_byte.valid_so_far = 1'b0;
          after_byte.stopped      = 1'b1;
          after_byte.cont_left    = 2'd0;
        end else begin
          after_byte.cont_left = state_i.cont_left - 2'd1;
          if (state_i.cont_left == 2'd1) after_byte.require_so_far = 1'b1;
        end
      end else if (special) begin
        if (b < AsciiLimit) begin
          after_byte.require_so_far = 1'b1;
        end else if (b[7:5] == Lead2Tag) begin
          after_byte.cont_left = 2'd1;
        end else if (b[7:4] == Lead3Tag) begin
          after_byte.cont_left = 2'd2;
        end else if (b[7:3] == Lead4Tag) begin
          after_byte.cont_left = 2'd3;
        end else begin
          // stray continuation or invalid lead
          after_byte.valid_so_far = 1'b0;
          after_byte.stopped      = 1'b1;
          after_byte.cont_left    = 2'd0;
        end
      end
    end
  end

  // End of name: a sequence still open is a framing error
  always_comb begin
    at_end = after_byte;
    if (!after_byte.stopped && (after_byte.cont_left != 2'd0)) begin
      at_end.valid_so_far = 1'b0;
    end
  end

  assign result_o.utf8_valid      = at_end.valid_so_far;
  assign result_o.needs_utf8_flag = at_end.require_so_far;
  assign state_o = item_i.last_byte ? StateReset : after_byte;

endmodule

`default_nettype wire

@@ hw/rtl/utf8_name_flag_detector.sv @@
// ----------------------------------------------------------------------------
// utf8_name_flag_detector
// Checks UTF-8 framing of a name streamed at most one byte per item and reports,
// on the last item, whether it is valid and whether it needs the UTF-8 flag.
// ----------------------------------------------------------------------------
// A name's last item passes the input register, then the result register.
// Throughput: one item per cycle; input and result register hold one each, and
//   input stalls only when a last item finds the result register still full.
// Reset: synchronous, active low; clears both stage valids and returns the
//   per-name state to its empty-name value.
`default_nettype none

module utf8_name_flag_detector (
  input  wire logic   clk,
  input  wire logic   rst_n,
  utf8nf_in_if.sink   in_ch,
  utf8nf_out_if.source out_ch
);
  import utf8nf_pkg::*;

  logic           s1_valid_r;
  utf8nf_item_t   s1_item_r;
  utf8nf_state_t  state_r;
  utf8nf_state_t  state_nxt;
  utf8nf_result_t result_nxt;
  logic           out_valid_r;
  utf8nf_result_t out_result_r;
  logic           out_free;
  logic           s1_fire;
  logic           in_fire;

  // Handshake control
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.data_byte    <= in_ch.data_byte;
      s1_item_r.byte_present <= in_ch.byte_present;
      s1_item_r.last_byte    <= in_ch.last_byte;
    end
  end

  utf8nf_byte_step u_step (
    .state_i  (state_r),
    .item_i   (s1_item_r),
    .state_o  (state_nxt),
    .result_o (result_nxt)
  );

  // Per-name state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StateReset;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_fire && s1_item_r.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.last_byte) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.utf8_valid      = out_result_r.utf8_valid;
  assign out_ch.needs_utf8_flag = out_result_r.needs_utf8_flag;

  // A reported name leaves the state clean for the next one
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.last_byte) |=> (state_r == StateReset))
    else $error("state not cleared after end of name");

  // A framing stop always carries an invalid mark
  a_stop_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stopped |-> !state_r.valid_so_far)
    else $error("stopped without invalid mark");

  // Once stopped, no sequence is left open
  a_stop_no_cont: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.stopped |-> (state_r.cont_left == 2'd0))
    else $error("stopped with open sequence");

  // A new result only follows a last-marked item leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_item_r.last_byte))
    else $error("result without last item");

endmodule

`default_nettype wire

@@ tb/utf8_name_flag_detector_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_name_flag_detector_tb
// Streams name bytes into the detector and checks each per-name result
// against a local predictor of framing and flag rules. A directed set of
// names comes first. Random names follow, mostly well-framed sequences with
// noise mixed in. Runs go with and without random idling on both channels,
// and one run holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_name_flag_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8nf_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 200;
  localparam int PhaseItems = 280;

  // One pending input item; drain_first holds it back until no result is due
  typedef struct {
    utf8nf_item_t item;
    bit           drain_first;
  } name_entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  utf8nf_in_if  in_ch ();
  utf8nf_out_if out_ch ();

  utf8_name_flag_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  name_entry_t    name_bytes_q[$];
  utf8nf_result_t flag_results_q[$];
  utf8nf_state_t  name_scan = StateReset;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_cnt = 0;
  int unsigned items_queued = 0;
  int unsigned mismatches = 0;

  always #5 clk = ~clk;

  // Known values on every block input before reset releases
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Framing tracker: one byte of the current name
  function automatic void scan_name_byte(input logic [7:0] b);
    if (name_scan.stopped) return;
    if (name_scan.cont_left != 2'd0) begin
      if (b[7:6] != ContTag) begin
        name_scan.valid_so_far = 1'b0;
        name_scan.stopped = 1'b1;
        name_scan.cont_left = 2'd0;
        return;
      end
      name_scan.cont_left = name_scan.cont_left - 2'd1;
      if (name_scan.cont_left == 2'd0) name_scan.require_so_far = 1'b1;
      return;
    end
    if (b < CtrlLimit || b > PrintMax || b == Backslash) begin
      if (b < AsciiLimit) begin
        name_scan.require_so_far = 1'b1;
      end else if (b[7:5] == Lead2Tag) begin
        name_scan.cont_left = 2'd1;
      end else if (b[7:4] == Lead3Tag) begin
        name_scan.cont_left = 2'd2;
      end else if (b[7:3] == Lead4Tag) begin
        name_scan.cont_left = 2'd3;
      end else begin
        // stray continuation or lead of 0xf8 and above
        name_scan.valid_so_far = 1'b0;
        name_scan.stopped = 1'b1;
        name_scan.cont_left = 2'd0;
      end
    end
  endfunction

  // Accepted item: update tracker, queue the name's result on the last mark
  function automatic void predict_name_item(input utf8nf_item_t it);
    utf8nf_result_t r;
    if (it.byte_present) scan_name_byte(it.data_byte);
    if (it.last_byte) begin
      // open sequence at the end of the name
      if (!name_scan.stopped && name_scan.cont_left != 2'd0) name_scan.valid_so_far = 1'b0;
      r.utf8_valid = name_scan.valid_so_far;
      r.needs_utf8_flag = name_scan.require_so_far;
      flag_results_q.push_back(r);
      name_scan = StateReset;
    end
  endfunction

  // Driver
  always @(posedge clk) begin : drv
    name_entry_t nxt;
    bit          send;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_name_item('{in_ch.data_byte, in_ch.byte_present, in_ch.last_byte});
      end
      if (!in_ch.valid || in_ch.ready) begin
        send = 1'b0;
        if (name_bytes_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          if (!name_bytes_q[0].drain_first || flag_results_q.size() == 0) begin
            nxt = name_bytes_q.pop_front();
            send = 1'b1;
            in_ch.data_byte <= nxt.item.data_byte;
            in_ch.byte_present <= nxt.item.byte_present;
            in_ch.last_byte <= nxt.item.last_byte;
          end
        end
        in_ch.valid <= send;
      end
    end
  end

  // Long hold-off of the result side
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_req;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor and checker
  always @(posedge clk) begin : mon
    utf8nf_result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (flag_results_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual valid=%0b flag=%0b",
                   $time, out_ch.utf8_valid, out_ch.needs_utf8_flag);
          mismatches++;
        end else begin
          want = flag_results_q.pop_front();
          if (out_ch.utf8_valid !== want.utf8_valid) begin
            $display("%0t: utf8_valid mismatch: expected %0b, actual %0b",
                     $time, want.utf8_valid, out_ch.utf8_valid);
            mismatches++;
          end
          if (out_ch.needs_utf8_flag !== want.needs_utf8_flag) begin
            $display("%0t: needs_utf8_flag mismatch: expected %0b, actual %0b",
                     $time, want.needs_utf8_flag, out_ch.needs_utf8_flag);
            mismatches++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic add_item(input logic [7:0] b, input bit present, input bit last,
                          input bit drain_first = 1'b0);
    name_entry_t e;
    e.item.data_byte = b;
    e.item.byte_present = present;
    e.item.last_byte = last;
    e.drain_first = drain_first;
    name_bytes_q.push_back(e);
    if (present || last) items_queued++;
  endtask

  // Random name: mostly well-formed sequences, some noise and broken ones
  task automatic add_random_name();
    utf8nf_item_t parts[$];
    utf8nf_item_t it;
    int           segs;
    int           kind;
    int           len;
    int           cut;
    segs = $urandom_range(0, 5);
    for (int s = 0; s < segs; s++) begin
      kind = $urandom_range(99);
      it.byte_present = 1'b1;
      it.last_byte = 1'b0;
      if (kind < 35) begin
        it.data_byte = 8'($urandom_range(CtrlLimit, PrintMax));
        parts.push_back(it);
      end else if (kind < 45) begin
        case ($urandom_range(3))
          0: it.data_byte = 8'($urandom_range(0, CtrlLimit - 1));
          1: it.data_byte = 8'h7e;
          2: it.data_byte = 8'h7f;
          default: it.data_byte = Backslash;
        endcase
        parts.push_back(it);
      end else if (kind < 80) begin
        len = $urandom_range(2, 4);
        case (len)
          2: it.data_byte = {Lead2Tag, 5'($urandom)};
          3: it.data_byte = {Lead3Tag, 4'($urandom)};
          default: it.data_byte = {Lead4Tag, 3'($urandom)};
        endcase
        parts.push_back(it);
        // now and then cut the sequence short or corrupt a continuation
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, len - 1) : len;
        for (int k = 1; k < len && k <= cut; k++) begin
          if (k == cut) it.data_byte = 8'($urandom);
          else it.data_byte = {ContTag, 6'($urandom)};
          parts.push_back(it);
        end
      end else if (kind < 90) begin
        it.data_byte = 8'($urandom);
        parts.push_back(it);
      end else begin
        it.data_byte = 8'($urandom);
        it.byte_present = 1'b0;
        parts.push_back(it);
      end
    end
    if (parts.size() == 0 || $urandom_range(4) == 0) begin
      it.data_byte = 8'($urandom);
      it.byte_present = 1'b0;
      it.last_byte = 1'b1;
      parts.push_back(it);
    end else begin
      parts[parts.size() - 1].last_byte = 1'b1;
    end
    foreach (parts[i]) add_item(parts[i].data_byte, parts[i].byte_present, parts[i].last_byte);
  endtask

  task automatic wait_inputs_taken();
    while (name_bytes_q.size() != 0 || in_ch.valid) @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed names
    add_item(8'h00, 1'b0, 1'b1);                                   // empty name
    add_item(8'h61, 1'b1, 1'b0);                                   // bytes, idle, terminator
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h5a, 1'b0, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);                                   // control byte
    add_item(8'hff, 1'b1, 1'b1);                                   // invalid lead
    add_item(8'h7e, 1'b1, 1'b1);
    add_item(Backslash, 1'b1, 1'b1);
    add_item(8'h20, 1'b1, 1'b1);
    add_item(PrintMax, 1'b1, 1'b1);
    add_item(8'hc3, 1'b1, 1'b0);                                   // two-byte
    add_item(8'ha9, 1'b1, 1'b1);
    add_item(8'he2, 1'b1, 1'b0);                                   // three-byte
    add_item(8'h82, 1'b1, 1'b0);
    add_item(8'hac, 1'b1, 1'b1);
    add_item(8'hf0, 1'b1, 1'b0);                                   // four-byte
    add_item(8'h9f, 1'b1, 1'b0);
    add_item(8'h98, 1'b1, 1'b0);
    add_item(8'h80, 1'b1, 1'b1);
    add_item(8'hbf, 1'b1, 1'b0);                                   // stray continuation,
    add_item(8'h01, 1'b1, 1'b1);                                   // later control ignored
    add_item(8'hc3, 1'b1, 1'b0);                                   // broken sequence
    add_item(8'h41, 1'b1, 1'b1);
    add_item(8'he2, 1'b1, 1'b0);                                   // cut-off sequence
    add_item(8'h82, 1'b1, 1'b1);
    wait_inputs_taken();

    // Back-pressure: hold results off while single-byte names pour in
    hold_req++;
    for (int i = 0; i < 60; i++) add_item(8'($urandom), 1'b1, 1'b1);
    // then pause the input until every result is out
    add_item(8'($urandom), 1'b1, 1'b1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      wait_inputs_taken();
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 69; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 69; end
        default: begin src_idle_pct = 6; snk_stall_pct = 6; end
      endcase
      target = items_queued + PhaseItems;
      while (items_queued < target) add_random_name();
    end
    wait_inputs_taken();
    while (flag_results_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/utf8nf_pkg.sv
hw/rtl/utf8nf_if.sv
hw/rtl/utf8nf_byte_step.sv
hw/rtl/utf8_name_flag_detector.sv
tb/utf8_name_flag_detector_tb.sv
